>>> hw/rtl/sliding_window_maximum_top_defines.svh
// assertion macros for the sliding window maximum block
`ifndef SLIDING_WINDOW_MAXIMUM_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on clk outside reset
`define SWM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swm assertion failed");

// next-cycle implication, checked on clk outside reset
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swm assertion failed");

`else

`define SWM_ASSERT_IMPL(lbl, ante, cons)
`define SWM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hw/rtl/swm_pkg.sv
// shared types and constants for the sliding window maximum block
`default_nettype none

package swm_pkg;

  // width of the window size register
  localparam int CFG_W = 7;
  // width of the result field
  localparam int OUT_W = 16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // latch input beat, apply restart
    logic rd_front;    // read queue front entry
    logic rd_back;     // read queue back entry
    logic drop_front;  // pop aged front entry
    logic keep_front;  // remember front value
    logic drop_back;   // pop smaller back entry
    logic append;      // push new sample, advance counters
    logic load_out;    // load result register
  } swm_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic empty;       // queue holds no entry
    logic aged;        // entry just read has left the window
    logic smaller;     // entry just read is below the new sample
    logic emit;        // window full after this sample
    logic out_busy;    // result register still occupied next cycle
  } swm_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/swm_ctrl.sv
// controller state machine sequencing the queue updates for one sample
`default_nettype none

module swm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire swm_pkg::swm_status_t sts,
  output swm_pkg::swm_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FRONT_REQ,
    S_FRONT_CHK,
    S_BACK_REQ,
    S_BACK_CHK,
    S_APPEND,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_FRONT_REQ;
        end
      end
      S_FRONT_REQ: begin
        if (sts.empty) begin
          state_next = S_BACK_REQ;
        end else begin
          cmd.rd_front = 1'b1;
          state_next   = S_FRONT_CHK;
        end
      end
      S_FRONT_CHK: begin
        if (sts.aged) begin
          cmd.drop_front = 1'b1;
          state_next     = S_FRONT_REQ;
        end else begin
          cmd.keep_front = 1'b1;
          state_next     = S_BACK_REQ;
        end
      end
      S_BACK_REQ: begin
        if (sts.empty) begin
          state_next = S_APPEND;
        end else begin
          cmd.rd_back = 1'b1;
          state_next  = S_BACK_CHK;
        end
      end
      S_BACK_CHK: begin
        if (sts.smaller) begin
          cmd.drop_back = 1'b1;
          state_next    = S_BACK_REQ;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = sts.emit ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/swm_dp.sv
// datapath: candidate queue memory, pointers, counters and result register
`default_nettype none
`include "sliding_window_maximum_top_defines.svh"

module swm_dp #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [swm_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic [SAMPLE_WIDTH-1:0]   sample,
  input  wire logic                      restart,
  input  wire swm_pkg::swm_cmd_t         cmd,
  output swm_pkg::swm_status_t           sts,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [swm_pkg::OUT_W-1:0]      window_max
);

  localparam int AW     = $clog2(WINDOW_MAX);
  localparam int CW     = $clog2(WINDOW_MAX + 1);
  localparam int PW     = $clog2(2 * WINDOW_MAX);
  localparam int KW     = swm_pkg::CFG_W;
  localparam int AGW    = (PW > KW) ? PW : KW;

  // queue storage
  logic [SAMPLE_WIDTH-1:0] mem_val [WINDOW_MAX];
  logic [PW-1:0]           mem_pos [WINDOW_MAX];

  logic [KW-1:0]           window_size;
  logic [AW-1:0]           head;
  logic [CW-1:0]           count;
  logic [PW-1:0]           pos;
  logic [KW-1:0]           seen;
  logic [SAMPLE_WIDTH-1:0] cur_val;
  logic [SAMPLE_WIDTH-1:0] front_val;
  logic [SAMPLE_WIDTH-1:0] rd_val;
  logic [PW-1:0]           rd_pos;
  logic [swm_pkg::OUT_W-1:0] out_val;

  logic [KW-1:0]           k;
  logic [KW-1:0]           seen_next;
  logic [PW-1:0]           pos_next;
  logic [PW:0]             age;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;

  // ring index: head plus offset, offset below the depth
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(WINDOW_MAX)) begin
      s = s - (CW+1)'(WINDOW_MAX);
    end
    return AW'(s);
  endfunction

  // effective window: zero reads as one, clamp at the depth
  always_comb begin
    k = window_size;
    if (window_size == '0) begin
      k = KW'(1);
    end else if (32'(window_size) > WINDOW_MAX) begin
      k = KW'(WINDOW_MAX);
    end
  end

  // age of the entry just read, modulo twice the depth
  always_comb begin
    if (rd_pos <= pos) begin
      age = (PW+1)'(pos) - (PW+1)'(rd_pos);
    end else begin
      age = (PW+1)'(pos) + (PW+1)'(2 * WINDOW_MAX) - (PW+1)'(rd_pos);
    end
  end

  assign seen_next = (seen >= k) ? k : seen + KW'(1);
  assign pos_next  = (pos == PW'(2 * WINDOW_MAX - 1)) ? '0 : pos + PW'(1);
  assign rd_addr   = cmd.rd_front ? head : wrap(head, count - CW'(1));
  assign wr_addr   = wrap(head, count);

  // status
  always_comb begin
    sts.empty    = (count == '0);
    sts.aged     = (AGW'(age) >= AGW'(k));
    sts.smaller  = ($signed(rd_val) < $signed(cur_val));
    sts.emit     = (seen_next >= k);
    sts.out_busy = out_valid && !out_ready;
  end

  // queue memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem_val[wr_addr] <= cur_val;
      mem_pos[wr_addr] <= pos;
    end
    if (cmd.rd_front || cmd.rd_back) begin
      rd_val <= mem_val[rd_addr];
      rd_pos <= mem_pos[rd_addr];
    end
  end

  // control state: window register, pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= KW'(1);
      head        <= '0;
      count       <= '0;
      pos         <= '0;
      seen        <= '0;
    end else begin
      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
      end
      if (cmd.accept && restart) begin
        head  <= '0;
        count <= '0;
        pos   <= '0;
        seen  <= '0;
      end
      if (cmd.drop_front) begin
        head  <= wrap(head, CW'(1));
        count <= count - CW'(1);
      end
      if (cmd.drop_back) begin
        count <= count - CW'(1);
      end
      if (cmd.append) begin
        count <= count + CW'(1);
        pos   <= pos_next;
        seen  <= seen_next;
      end
    end
  end

  // sample and front value holding
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_val <= sample;
    end
    if (cmd.keep_front) begin
      front_val <= rd_val;
    end
  end

  // result register: a lone entry is the new sample itself
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_val <= (count == CW'(1)) ? swm_pkg::OUT_W'(cur_val)
                                   : swm_pkg::OUT_W'(front_val);
    end
  end

  assign window_max = out_val;

  // checks
  `SWM_ASSERT_IMPL(a_append_room, cmd.append, count < CW'(WINDOW_MAX))
  `SWM_ASSERT_IMPL(a_load_nonempty, cmd.load_out, count != '0)
  `SWM_ASSERT_IMPL(a_pop_nonempty, cmd.drop_front || cmd.drop_back, count != '0)
  `SWM_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid)

endmodule

`default_nettype wire

>>> hw/rtl/sliding_window_maximum_top.sv
// Sliding window maximum over a signed sample stream.
// Input channel: in_valid/in_ready carry one beat of sample and restart.
// Output channel: out_valid/out_ready carry one beat of window_max, given
// once at least window_size samples have arrived since the last restart.
// Configuration: cfg_wr_en writes cfg_wr_data into window_size at once.
// One sample at a time is processed by a controller stepping through a
// queue memory with one read port and a registered read:
//   it reads and pops aged front entries, keeps the surviving front
//   value, reads and pops back entries below the new sample, appends
//   the sample and, when a result is made, loads the result register;
// the worst case grows with window_size since each queue entry costs
// one read and one compare.
// The result leaves from its own register, so the next sample is taken
// while a result still waits; the block stalls only when a new result is
// ready and the old one has not yet been taken.
// Reset empties the queue, clears the counters and sets window_size to 1;
// the memory needs no clearing pass.
`default_nettype none

module sliding_window_maximum_top #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [swm_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [SAMPLE_WIDTH-1:0]   sample,
  input  wire logic                      restart,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [swm_pkg::OUT_W-1:0]      window_max
);

  swm_pkg::swm_cmd_t    cmd;
  swm_pkg::swm_status_t sts;

  // sequencer
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // queue and counters
  swm_dp #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (sample),
    .restart     (restart),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .window_max  (window_max)
  );

endmodule

`default_nettype wire
